[hdl/rrta_pkg.sv]
// rrta_pkg: shared constants, field layout and controller/datapath
// command and status types of the ring route traffic accumulator
// no dependencies
package rrta_pkg;

	localparam int RING_NODES_DEF   = 16;
	localparam int SUBNETS_DEF      = 3;
	localparam int COUNTER_BITS_DEF = 48;

	localparam int IN_PORTS  = 3;
	localparam int OUT_PORTS = 2;

	localparam int RING_SIZE_W = 5;
	localparam logic [RING_SIZE_W-1:0] RING_SIZE_RST = 5'd16;

	localparam int KIND_W  = 2;
	localparam int NODE_W  = 4;
	localparam int AMT_W   = 32;
	localparam int SUB_W   = 2;
	localparam int PORT_W  = 2;
	localparam int VALUE_W = 48;

	localparam logic [KIND_W-1:0] KIND_MARK  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	localparam logic [PORT_W-1:0] PORT_LOCAL = 2'd0;
	localparam logic [PORT_W-1:0] PORT_VC0   = 2'd1;
	localparam logic [PORT_W-1:0] PORT_VC1   = 2'd2;

	localparam logic OP_EJECT = 1'b0;
	localparam logic OP_RING  = 1'b1;

	// input tdata layout
	localparam int S_SRC_LSB  = 0;
	localparam int S_DST_LSB  = 4;
	localparam int S_AMT_LSB  = 8;
	localparam int S_SUB_LSB  = 40;
	localparam int S_RN_LSB   = 42;
	localparam int S_RIP_LSB  = 46;
	localparam int S_ROP_LSB  = 48;
	localparam int S_TDATA_W  = 56;

	// output tdata layout
	localparam int M_ERR_BIT  = 48;
	localparam int M_SAT_BIT  = 49;
	localparam int M_PAD_W    = 6;
	localparam int M_TDATA_W  = 56;

	typedef struct packed {
		logic load;
		logic sweep;
		logic rd;
		logic wr;
		logic adv;
		logic cap;
		logic res;
	} dp_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              bad_mark;
		logic              bad_read;
		logic              at_dst;
		logic              sweep_last;
	} dp_sts_t;

endpackage

[hdl/ring_route_traffic_accumulator_top.sv]
// ring route traffic accumulator top level
// a mark walks hops + 1 counters to its result, hops from 0 to the effective ring size - 1,
// one read-modify-write of the counter ram per touched counter; a read does one ram read
// a clear sweeps the ram one entry per cycle, all SUBNETS * RING_NODES * 6 entries
// one transaction at a time, s_tready returns high as a result is registered
// async reset: ring_size 16, then a zeroing sweep of all 288 (default) entries with s_tready low
module ring_route_traffic_accumulator_top import rrta_pkg::*; #(
	parameter int RING_NODES   = RING_NODES_DEF,
	parameter int SUBNETS      = SUBNETS_DEF,
	parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [RING_SIZE_W-1:0] cfg_wdata,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// src_node, dst_node, traffic_amount, subnet, read_node, read_in_port, read_out_port
	input  logic [S_TDATA_W-1:0]   s_tdata,
	// kind
	input  logic [KIND_W-1:0]      s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// read_value, error, saturated
	output logic [M_TDATA_W-1:0]   m_tdata
);

	dp_cmd_t              cmd;
	dp_sts_t              sts;
	logic [VALUE_W-1:0]   res_value;
	logic                 res_error;
	logic                 res_saturated;

	rrta_dp #(
		.RING_NODES   (RING_NODES),
		.SUBNETS      (SUBNETS),
		.COUNTER_BITS (COUNTER_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_kind       (s_tuser),
		.in_src        (s_tdata[S_SRC_LSB +: NODE_W]),
		.in_dst        (s_tdata[S_DST_LSB +: NODE_W]),
		.in_amt        (s_tdata[S_AMT_LSB +: AMT_W]),
		.in_sub        (s_tdata[S_SUB_LSB +: SUB_W]),
		.in_rnode      (s_tdata[S_RN_LSB +: NODE_W]),
		.in_rip        (s_tdata[S_RIP_LSB +: PORT_W]),
		.in_rop        (s_tdata[S_ROP_LSB]),
		.cmd           (cmd),
		.sts           (sts),
		.res_value     (res_value),
		.res_error     (res_error),
		.res_saturated (res_saturated)
	);

	rrta_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	assign m_tdata = {{M_PAD_W{1'b0}}, res_saturated, res_error, res_value};

endmodule

[hdl/rrta_ram.sv]
// rrta_ram: generic single write port, single read port ram
// registered read data, no reset on the array; no dependencies
module rrta_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 288
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/rrta_dp.sv]
// rrta_dp: datapath with request registers, ring walk position, counter
// address, saturating add, clear sweep counter and result registers
// depends on rrta_pkg and rrta_ram
module rrta_dp import rrta_pkg::*; #(
	parameter int RING_NODES   = RING_NODES_DEF,
	parameter int SUBNETS      = SUBNETS_DEF,
	parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [RING_SIZE_W-1:0] cfg_wdata,
	input  logic [KIND_W-1:0]      in_kind,
	input  logic [NODE_W-1:0]      in_src,
	input  logic [NODE_W-1:0]      in_dst,
	input  logic [AMT_W-1:0]       in_amt,
	input  logic [SUB_W-1:0]       in_sub,
	input  logic [NODE_W-1:0]      in_rnode,
	input  logic [PORT_W-1:0]      in_rip,
	input  logic                   in_rop,
	input  dp_cmd_t                cmd,
	output dp_sts_t                sts,
	output logic [VALUE_W-1:0]     res_value,
	output logic                   res_error,
	output logic                   res_saturated
);

	localparam int DEPTH      = SUBNETS * RING_NODES * IN_PORTS * OUT_PORTS;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CUR_W      = $clog2(RING_NODES);
	localparam int NODE_CNT_W = $clog2(RING_NODES + 1);
	localparam int CMP_W      = (NODE_CNT_W > RING_SIZE_W) ? NODE_CNT_W : RING_SIZE_W;

	logic [RING_SIZE_W-1:0]  ring_size_q;
	logic [KIND_W-1:0]       kind_q;
	logic [NODE_W-1:0]       src_q;
	logic [NODE_W-1:0]       dst_q;
	logic [AMT_W-1:0]        amt_q;
	logic [SUB_W-1:0]        sub_q;
	logic [NODE_W-1:0]       rnode_q;
	logic [PORT_W-1:0]       rip_q;
	logic                    rop_q;
	logic [CUR_W-1:0]        cur_q;
	logic [PORT_W-1:0]       port_q;
	logic                    sat_q;
	logic [COUNTER_BITS-1:0] val_q;
	logic [ADDR_W-1:0]       sweep_q;

	logic [CMP_W-1:0]        ring_x;
	logic [CMP_W-1:0]        eff_n;
	logic                    at_dst;
	logic                    last_node;
	logic [ADDR_W-1:0]       node_a;
	logic [ADDR_W-1:0]       ip_a;
	logic                    op_a;
	logic [ADDR_W-1:0]       addr;
	logic [COUNTER_BITS-1:0] rdata;
	logic [COUNTER_BITS:0]   sum;
	logic                    we;
	logic [ADDR_W-1:0]       waddr;
	logic [COUNTER_BITS-1:0] wdata;

	// effective ring size, clamped to 2..RING_NODES
	always_comb begin
		ring_x = CMP_W'(ring_size_q);
		if (ring_x < CMP_W'(2)) begin
			eff_n = CMP_W'(2);
		end else if (ring_x > CMP_W'(RING_NODES)) begin
			eff_n = CMP_W'(RING_NODES);
		end else begin
			eff_n = ring_x;
		end
	end

	assign at_dst    = (CMP_W'(cur_q) == CMP_W'(dst_q));
	assign last_node = (CMP_W'(cur_q) == eff_n - CMP_W'(1));

	assign sts.kind       = kind_q;
	assign sts.bad_mark   = (CMP_W'(src_q) >= eff_n) || (CMP_W'(dst_q) >= eff_n) ||
	                        (4'(sub_q) >= 4'(SUBNETS));
	assign sts.bad_read   = (CMP_W'(rnode_q) >= eff_n) || (rip_q >= PORT_W'(IN_PORTS)) ||
	                        (4'(sub_q) >= 4'(SUBNETS));
	assign sts.at_dst     = at_dst;
	assign sts.sweep_last = (sweep_q == ADDR_W'(DEPTH - 1));

	// counter address: ((subnet * nodes + node) * in ports + in port) * out ports + out port
	always_comb begin
		if (kind_q == KIND_READ) begin
			node_a = ADDR_W'(rnode_q);
			ip_a   = ADDR_W'(rip_q);
			op_a   = rop_q;
		end else begin
			node_a = ADDR_W'(cur_q);
			ip_a   = ADDR_W'(port_q);
			op_a   = at_dst ? OP_EJECT : OP_RING;
		end
		addr = ((ADDR_W'(sub_q) * ADDR_W'(RING_NODES) + node_a) * ADDR_W'(IN_PORTS) + ip_a)
		       * ADDR_W'(OUT_PORTS) + ADDR_W'(op_a);
	end

	assign sum = {1'b0, rdata} + (COUNTER_BITS + 1)'(amt_q);

	always_comb begin
		we    = cmd.sweep | cmd.wr;
		waddr = cmd.sweep ? sweep_q : addr;
		if (cmd.sweep) begin
			wdata = '0;
		end else if (sum[COUNTER_BITS]) begin
			wdata = '1;
		end else begin
			wdata = sum[COUNTER_BITS-1:0];
		end
	end

	rrta_ram #(
		.WIDTH(COUNTER_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.rd),
		.raddr (addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_size_q <= RING_SIZE_RST;
			sweep_q     <= '0;
		end else begin
			if (cfg_we) begin
				ring_size_q <= cfg_wdata;
			end
			if (cmd.sweep) begin
				sweep_q <= sts.sweep_last ? '0 : sweep_q + ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= in_kind;
			src_q   <= in_src;
			dst_q   <= in_dst;
			amt_q   <= in_amt;
			sub_q   <= in_sub;
			rnode_q <= in_rnode;
			rip_q   <= in_rip;
			rop_q   <= in_rop;
			cur_q   <= CUR_W'(in_src);
			port_q  <= PORT_LOCAL;
			sat_q   <= 1'b0;
			val_q   <= '0;
		end else begin
			if (cmd.wr && sum[COUNTER_BITS]) begin
				sat_q <= 1'b1;
			end
			if (cmd.adv) begin
				if (last_node) begin
					cur_q  <= '0;
					port_q <= (port_q != PORT_LOCAL) ? PORT_VC1 : PORT_VC0;
				end else begin
					cur_q <= cur_q + CUR_W'(1);
					if (port_q == PORT_LOCAL) begin
						port_q <= PORT_VC0;
					end
				end
			end
			if (cmd.cap) begin
				val_q <= rdata;
			end
		end
		if (cmd.res) begin
			res_value     <= (kind_q == KIND_READ && !sts.bad_read) ? VALUE_W'(val_q) : '0;
			res_error     <= (kind_q == KIND_MARK && sts.bad_mark) ||
			                 (kind_q == KIND_READ && sts.bad_read);
			res_saturated <= (kind_q == KIND_MARK) && sat_q;
		end
	end

endmodule

[hdl/rrta_ctrl.sv]
// rrta_ctrl: controller state machine sequencing table sweep, ring walk
// read-modify-write and result hand-off; depends on rrta_pkg
module rrta_ctrl import rrta_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_RD    = 3'd3;
	localparam logic [2:0] ST_MOD   = 3'd4;
	localparam logic [2:0] ST_CLR   = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       m_tvalid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_INIT: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				case (sts.kind)
					KIND_MARK:  state_d = sts.bad_mark ? ST_FIN : ST_RD;
					KIND_READ:  state_d = sts.bad_read ? ST_FIN : ST_RD;
					KIND_CLEAR: state_d = ST_CLR;
					default:    state_d = ST_FIN;
				endcase
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_MOD;
			end
			ST_MOD: begin
				if (sts.kind == KIND_READ) begin
					cmd.cap = 1'b1;
					state_d = ST_FIN;
				end else begin
					cmd.wr = 1'b1;
					if (sts.at_dst) begin
						state_d = ST_FIN;
					end else begin
						cmd.adv = 1'b1;
						state_d = ST_RD;
					end
				end
			end
			ST_CLR: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.res = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

[hdl/rrta_chk.sv]
// rrta_chk: port-level checker for the ring route traffic accumulator
// bound to the top level; depends on rrta_pkg
module rrta_chk import rrta_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [M_TDATA_W-1:0]   m_tdata
);

	// one transaction in flight: ready drops right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while a transaction is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	a_err_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[M_ERR_BIT] |-> m_tdata[VALUE_W-1:0] == '0)
		else $error("error result carries a counter value");

	a_err_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[M_ERR_BIT] && m_tdata[M_SAT_BIT]))
		else $error("error and saturated both set");

	// a result never shows on the output straight after an accept made while the output was empty
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result appeared too early");

endmodule

bind ring_route_traffic_accumulator_top rrta_chk u_rrta_chk (.*);

[bench/tb_top.sv]
// tb_top: self-checking bench for ring_route_traffic_accumulator_top, with a
// scoreboard that mirrors the counter table and walks each route on its own
// depends on rrta_pkg and the top level of the block
`timescale 1ns / 1ps

module tb_top import rrta_pkg::*; ();

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int TABLE_DEPTH = SUBNETS_DEF * RING_NODES_DEF * IN_PORTS * OUT_PORTS;
	localparam logic [VALUE_W-1:0] COUNTER_MAX = {COUNTER_BITS_DEF{1'b1}};

	typedef struct packed {
		logic [VALUE_W-1:0] read_value;
		logic               error;
		logic               saturated;
	} route_outcome_t;

	class route_scoreboard;
		logic [VALUE_W-1:0] counters [TABLE_DEPTH];
		logic [RING_SIZE_W-1:0] ring_size;
		route_outcome_t outcome_q[$];
		int errors;

		function new();
			ring_size = RING_SIZE_RST;
			errors = 0;
			foreach (counters[i]) counters[i] = '0;
		endfunction

		function int eff_ring();
			if (ring_size < 2) return 2;
			if (ring_size > RING_NODES_DEF) return RING_NODES_DEF;
			return int'(ring_size);
		endfunction

		function int slot(int s, int r, int ip, int op);
			return ((s * RING_NODES_DEF + r) * IN_PORTS + ip) * OUT_PORTS + op;
		endfunction

		function bit accumulate(int s, int r, int ip, int op, logic [AMT_W-1:0] amt);
			int k;
			logic [VALUE_W:0] sum;
			k = slot(s, r, ip, op);
			sum = {1'b0, counters[k]} + (VALUE_W + 1)'(amt);
			if (sum[VALUE_W]) begin
				counters[k] = COUNTER_MAX;
				return 1'b1;
			end
			counters[k] = sum[VALUE_W-1:0];
			return 1'b0;
		endfunction

		function void note_request(logic [KIND_W-1:0] kind, logic [NODE_W-1:0] src,
				logic [NODE_W-1:0] dst, logic [AMT_W-1:0] amt, logic [SUB_W-1:0] sub,
				logic [NODE_W-1:0] rn, logic [PORT_W-1:0] rip, logic rop);
			route_outcome_t res;
			int n;
			int cur;
			int hops;
			logic [PORT_W-1:0] port;
			res = '0;
			n = eff_ring();
			if (kind == KIND_MARK) begin
				if (int'(src) >= n || int'(dst) >= n || int'(sub) >= SUBNETS_DEF) begin
					res.error = 1'b1;
				end else begin
					cur = int'(src);
					port = PORT_LOCAL;
					hops = 0;
					while (cur != int'(dst) && hops < n) begin
						if (accumulate(int'(sub), cur, int'(port), int'(OP_RING), amt))
							res.saturated = 1'b1;
						if (cur < n - 1) begin
							cur++;
							if (port == PORT_LOCAL) port = PORT_VC0;
						end else begin
							cur = 0;
							port = (port != PORT_LOCAL) ? PORT_VC1 : PORT_VC0;
						end
						hops++;
					end
					if (accumulate(int'(sub), cur, int'(port), int'(OP_EJECT), amt))
						res.saturated = 1'b1;
				end
			end else if (kind == KIND_READ) begin
				if (int'(rn) >= n || int'(rip) >= IN_PORTS || int'(sub) >= SUBNETS_DEF)
					res.error = 1'b1;
				else
					res.read_value = counters[slot(int'(sub), int'(rn), int'(rip), int'(rop))];
			end else if (kind == KIND_CLEAR) begin
				foreach (counters[i]) counters[i] = '0;
			end
			outcome_q = {outcome_q, res};
		endfunction

		function void compare(string name, logic [VALUE_W-1:0] exp_v, logic [VALUE_W-1:0] act_v);
			if (exp_v !== act_v) begin
				$error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] data);
			route_outcome_t exp_r;
			if (outcome_q.size() == 0) begin
				$error("result transaction 0x%0h with nothing expected", data);
				errors++;
				return;
			end
			exp_r = outcome_q.pop_front();
			compare("read_value", exp_r.read_value, data[VALUE_W-1:0]);
			compare("error", VALUE_W'(exp_r.error), VALUE_W'(data[M_ERR_BIT]));
			compare("saturated", VALUE_W'(exp_r.saturated), VALUE_W'(data[M_SAT_BIT]));
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [RING_SIZE_W-1:0] cfg_wdata;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata;
	logic [KIND_W-1:0]      s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [M_TDATA_W-1:0]   m_tdata;

	bit s_idle_on;
	bit m_idle_on;
	route_scoreboard sb;

	ring_route_traffic_accumulator_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("ring_route_traffic_accumulator_top test failed");
		$finish;
	end

	task automatic send(logic [KIND_W-1:0] kind, logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst,
			logic [AMT_W-1:0] amt, logic [SUB_W-1:0] sub, logic [NODE_W-1:0] rn,
			logic [PORT_W-1:0] rip, logic rop);
		int gap;
		gap = s_idle_on ? $urandom_range(0, 17) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {7'd0, rop, rip, rn, sub, amt, dst, src};
		do @(posedge clk); while (!s_tready);
		sb.note_request(kind, src, dst, amt, sub, rn, rip, rop);
	endtask

	task automatic set_ring(logic [RING_SIZE_W-1:0] v);
		s_tvalid <= 1'b0;
		while (sb.outcome_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.ring_size = v;
	endtask

	task automatic random_burst(int count);
		logic [KIND_W-1:0] kind;
		logic [NODE_W-1:0] src, dst, rn;
		logic [AMT_W-1:0] amt;
		logic [SUB_W-1:0] sub;
		logic [PORT_W-1:0] rip;
		logic rop;
		int eff;
		int r;
		for (int i = 0; i < count; i++) begin
			r   = $urandom_range(0, 99);
			eff = sb.eff_ring();
			src = NODE_W'($urandom);
			dst = NODE_W'($urandom);
			amt = $urandom;
			sub = SUB_W'($urandom);
			rn  = NODE_W'($urandom);
			rip = PORT_W'($urandom);
			rop = 1'($urandom);
			if ($urandom_range(0, 11) != 0) begin
				src = NODE_W'($urandom_range(0, eff - 1));
				dst = NODE_W'($urandom_range(0, eff - 1));
				rn  = NODE_W'($urandom_range(0, eff - 1));
			end
			if ($urandom_range(0, 15) != 0) sub = SUB_W'($urandom_range(0, SUBNETS_DEF - 1));
			if ($urandom_range(0, 15) != 0) rip = PORT_W'($urandom_range(0, IN_PORTS - 1));
			case ($urandom_range(0, 7))
				0: amt = '1;
				1: amt = $urandom_range(0, 255);
				default: ;
			endcase
			if (r < 46) kind = KIND_MARK;
			else if (r < 91) kind = KIND_READ;
			else if (r < 94) kind = KIND_CLEAR;
			else kind = KIND_UNUSED;
			send(kind, src, dst, amt, sub, rn, rip, rop);
		end
	endtask

	initial begin
		int mode;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			mode = m_idle_on ? $urandom_range(0, 17) : 0;
			if (mode != 0) begin
				m_tready <= 1'b0;
				repeat (mode) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_result(m_tdata);
		end
	end

	initial begin
		logic [RING_SIZE_W-1:0] ring_plan [8];
		int mode;
		sb = new();
		ring_plan = '{5'd16, 5'd2, 5'd31, 5'd0, 5'd1, 5'd17, 5'd9, 5'd5};
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		s_idle_on = 1'b1;
		m_idle_on = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset value, source equals destination, wraps, bad indices
		send(KIND_READ,    0,  0, 32'd0,         0,  0, PORT_LOCAL, OP_EJECT);
		send(KIND_MARK,    0,  0, 32'hFFFF_FFFF, 0,  0, PORT_LOCAL, OP_EJECT);
		send(KIND_READ,    0,  0, 32'd0,         0,  0, PORT_LOCAL, OP_EJECT);
		send(KIND_MARK,   15,  1, 32'd1,         2,  0, PORT_LOCAL, OP_EJECT);
		send(KIND_READ,    0,  0, 32'd0,         2, 15, PORT_LOCAL, OP_RING);
		send(KIND_READ,    0,  0, 32'd0,         2,  0, PORT_VC0,   OP_RING);
		send(KIND_READ,    0,  0, 32'd0,         2,  1, PORT_VC0,   OP_EJECT);
		send(KIND_MARK,    3,  2, 32'h1234_5678, 1,  0, PORT_LOCAL, OP_EJECT);
		send(KIND_READ,    0,  0, 32'd0,         1,  0, PORT_VC1,   OP_RING);
		send(KIND_READ,    0,  0, 32'd0,         1,  2, PORT_VC1,   OP_EJECT);
		send(KIND_READ,    0,  0, 32'd0,         1, 15, PORT_VC0,   OP_RING);
		send(KIND_MARK,    0,  0, 32'd9,         3,  0, PORT_LOCAL, OP_EJECT);
		send(KIND_READ,    0,  0, 32'd0,         0,  3, 2'd3,       OP_RING);
		send(KIND_READ,    0,  0, 32'd0,         3,  3, PORT_VC0,   OP_RING);
		send(KIND_UNUSED, 15, 15, 32'hFFFF_FFFF, 3, 15, 2'd3,       OP_RING);
		send(KIND_MARK,    7,  8, 32'd0,         0,  0, PORT_LOCAL, OP_EJECT);
		send(KIND_CLEAR,   0,  0, 32'd0,         0,  0, PORT_LOCAL, OP_EJECT);
		send(KIND_READ,    0,  0, 32'd0,         1,  0, PORT_VC1,   OP_RING);
		set_ring(5'd4);
		send(KIND_MARK,    4,  0, 32'd3,         0,  0, PORT_LOCAL, OP_EJECT);
		send(KIND_READ,    0,  0, 32'd0,         0,  5, PORT_LOCAL, OP_RING);
		send(KIND_MARK,    3,  0, 32'd5,         0,  0, PORT_LOCAL, OP_EJECT);
		send(KIND_MARK,    2,  1, 32'd7,         0,  0, PORT_LOCAL, OP_EJECT);
		send(KIND_READ,    0,  0, 32'd0,         0,  0, PORT_VC0,   OP_EJECT);
		send(KIND_READ,    0,  0, 32'd0,         0,  0, PORT_VC1,   OP_RING);

		foreach (ring_plan[p]) begin
			set_ring(p == 7 ? 5'($urandom_range(0, 31)) : ring_plan[p]);
			mode = $urandom_range(0, 3);
			s_idle_on = mode[0];
			m_idle_on = mode[1];
			if (p == 0) begin
				s_idle_on = 1'b1;
				m_idle_on = 1'b1;
			end
			random_burst(94);
		end

		s_tvalid <= 1'b0;

		while (sb.outcome_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0) begin
			$display("ring_route_traffic_accumulator_top test passed");
		end else begin
			$display("ring_route_traffic_accumulator_top test failed");
		end
		$finish;
	end

endmodule
